FILE: rtl/onewire_master_sequencer_defines.svh
// Assertion macros shared by the checker files of the 1-Wire master sequencer.
// No dependencies; included by the checker module.
`ifndef ONEWIRE_MASTER_SEQUENCER_DEFINES_SVH
`define ONEWIRE_MASTER_SEQUENCER_DEFINES_SVH

// Generic clocked assertion with a synchronous, active-high reset as disable.
`define OWM_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, on the block's own clock and reset names.
`define OWM_ASSERT(lbl, prop, msg) \
   `OWM_ASSERT_AT(lbl, clock, reset, prop, msg)

`endif

FILE: rtl/owm_pkg.sv
// Shared types and constants for the 1-Wire master sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package owm_pkg;

   localparam int MAX_READ_BYTES = 15;
   localparam int WRITE_WIDTH    = 32;

   localparam int REQ_DATA_W = 40;   // 37 payload bits rounded up to bytes
   localparam int RSP_DATA_W = 24;   // 17 payload bits rounded up to bytes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_RESET_TICKS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INIT_LOW_TICKS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RECOVERY_TICKS = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SLOT_TICKS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_DELAY   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_END_WAIT_TICKS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_END_WAIT_PER   = 3'd6;

   // Register reset values
   localparam logic [15:0] RST_RESET_TICKS    = 16'd480;
   localparam logic [7:0]  RST_INIT_LOW_TICKS = 8'd2;
   localparam logic [7:0]  RST_RECOVERY_TICKS = 8'd2;
   localparam logic [15:0] RST_SLOT_TICKS     = 16'd60;
   localparam logic [7:0]  RST_SAMPLE_DELAY   = 8'd8;
   localparam logic [15:0] RST_END_WAIT_TICKS = 16'd50000;
   localparam logic [3:0]  RST_END_WAIT_PER   = 4'd10;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [7:0] {
      PH_IDLE       = 8'b0000_0001,
      PH_RESET_LOW  = 8'b0000_0010,
      PH_PRESENCE   = 8'b0000_0100,
      PH_RECOVERY   = 8'b0000_1000,
      PH_INIT_LOW   = 8'b0001_0000,
      PH_READ_DELAY = 8'b0010_0000,
      PH_HOLD       = 8'b0100_0000,
      PH_END_WAIT   = 8'b1000_0000
   } owm_phase_type;

   typedef struct packed {
      logic [15:0] reset_ticks;
      logic [7:0]  init_low_ticks;
      logic [7:0]  recovery_ticks;
      logic [15:0] slot_ticks;
      logic [7:0]  sample_delay_ticks;
      logic [15:0] end_wait_ticks;
      logic [3:0]  end_wait_periods;
   } owm_cfg_type;

   // Declared top down so that drive_low lands in bit 0 when packed
   typedef struct packed {
      logic       no_presence;
      logic       done_res;
      logic       busy_res;
      logic [3:0] byte_index;
      logic [7:0] read_byte;
      logic       byte_valid;
      logic       drive_low;
   } owm_rsp_type;

endpackage

FILE: rtl/owm_step.sv
// Sequencer state and single-tick next-state logic of the 1-Wire master.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  owm_pkg::owm_cfg_type  cfg,
   input  logic                  mode,
   input  logic                  line_level,
   input  logic [31:0]           write_data,
   input  logic [3:0]            read_count,
   output owm_pkg::owm_rsp_type  rsp
);
   import owm_pkg::*;

   owm_phase_type          phase_ff, phase_in;
   logic [15:0]            tick_ff, tick_in;
   logic [WRITE_WIDTH-1:0] wshift_ff, wshift_in;
   logic [3:0]             left_ff, left_in;
   logic [3:0]             total_ff, total_in;
   logic [2:0]             bitpos_ff, bitpos_in;
   logic [7:0]             rshift_ff, rshift_in;
   logic [3:0]             period_ff, period_in;
   logic                   pres_ff, pres_in;

   logic [15:0] len;
   logic [15:0] tick_nx;
   logic [3:0]  period_nx;
   logic [3:0]  periods_min;
   logic [3:0]  n_bytes;
   logic [7:0]  rshift_nx;
   logic        drive, valid, ended, nopres;
   logic [7:0]  rbyte;
   logic [3:0]  ridx;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      wshift_in = wshift_ff;
      left_in   = left_ff;
      total_in  = total_ff;
      bitpos_in = bitpos_ff;
      rshift_in = rshift_ff;
      period_in = period_ff;
      pres_in   = pres_ff;
      valid     = 1'b0;
      rbyte     = '0;
      ridx      = '0;
      ended     = 1'b0;
      nopres    = 1'b0;
      tick_nx   = tick_ff + 16'd1;
      period_nx = period_ff + 4'd1;
      periods_min = (cfg.end_wait_periods == 4'd0) ? 4'd1 : cfg.end_wait_periods;
      rshift_nx = rshift_ff | (8'(line_level) << bitpos_ff);
      n_bytes   = (32'(read_count) > MAX_READ_BYTES) ? 4'(MAX_READ_BYTES) : read_count;

      case (phase_ff)
         PH_RESET_LOW: drive = 1'b1;
         PH_INIT_LOW:  drive = 1'b1;
         PH_HOLD:      drive = (wshift_ff != '0) && !wshift_ff[0];
         default:      drive = 1'b0;
      endcase

      case (phase_ff)
         PH_RESET_LOW:  len = cfg.reset_ticks;
         PH_PRESENCE:   len = cfg.reset_ticks;
         PH_RECOVERY:   len = 16'(cfg.recovery_ticks);
         PH_INIT_LOW:   len = 16'(cfg.init_low_ticks);
         PH_READ_DELAY: len = 16'(cfg.sample_delay_ticks);
         PH_HOLD:       len = cfg.slot_ticks;
         default:       len = cfg.end_wait_ticks;
      endcase
      if (len == 16'd0) len = 16'd1;

      if (mode == MODE_START) begin
         if (phase_ff == PH_IDLE) begin
            wshift_in = WRITE_WIDTH'(write_data);
            left_in   = n_bytes;
            total_in  = n_bytes;
            bitpos_in = '0;
            rshift_in = '0;
            period_in = '0;
            pres_in   = 1'b0;
            phase_in  = PH_RESET_LOW;
            tick_in   = '0;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (phase_ff == PH_PRESENCE && !line_level) pres_in = 1'b1;
         tick_in = tick_nx;
         if (tick_nx >= len) begin
            tick_in = '0;
            case (phase_ff)
               PH_RESET_LOW: phase_in = PH_PRESENCE;
               PH_PRESENCE: begin
                  if (pres_in) begin
                     phase_in = PH_RECOVERY;
                  end else begin
                     phase_in = PH_IDLE;
                     ended    = 1'b1;
                     nopres   = 1'b1;
                  end
               end
               PH_RECOVERY: begin
                  if (wshift_ff != '0 || left_ff != 4'd0) begin
                     phase_in = PH_INIT_LOW;
                  end else begin
                     period_in = '0;
                     phase_in  = PH_END_WAIT;
                  end
               end
               PH_INIT_LOW: phase_in = (wshift_ff != '0) ? PH_HOLD : PH_READ_DELAY;
               PH_READ_DELAY: begin
                  rshift_in = rshift_nx;
                  bitpos_in = bitpos_ff + 3'd1;
                  // byte complete on the eighth sample
                  if (bitpos_ff == 3'd7) begin
                     valid     = 1'b1;
                     rbyte     = rshift_nx;
                     ridx      = total_ff - left_ff;
                     rshift_in = '0;
                     if (left_ff != 4'd0) left_in = left_ff - 4'd1;
                  end
                  phase_in = PH_HOLD;
               end
               PH_HOLD: begin
                  wshift_in = wshift_ff >> 1;
                  phase_in  = PH_RECOVERY;
               end
               default: begin
                  period_in = period_nx;
                  if (period_nx >= periods_min) begin
                     period_in = '0;
                     phase_in  = PH_IDLE;
                     ended     = 1'b1;
                  end
               end
            endcase
         end
      end

      rsp.drive_low   = drive;
      rsp.byte_valid  = valid;
      rsp.read_byte   = rbyte;
      rsp.byte_index  = ridx;
      rsp.busy_res    = (phase_in != PH_IDLE);
      rsp.done_res    = ended;
      rsp.no_presence = nopres;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         tick_ff   <= '0;
         wshift_ff <= '0;
         left_ff   <= '0;
         total_ff  <= '0;
         bitpos_ff <= '0;
         rshift_ff <= '0;
         period_ff <= '0;
         pres_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         wshift_ff <= wshift_in;
         left_ff   <= left_in;
         total_ff  <= total_in;
         bitpos_ff <= bitpos_in;
         rshift_ff <= rshift_in;
         period_ff <= period_in;
         pres_ff   <= pres_in;
      end
   end

endmodule

FILE: rtl/owm_outreg.sv
// Result register of the 1-Wire master: holds one response until taken.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module owm_outreg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  owm_pkg::owm_rsp_type rsp_in,
   output logic                 can_load,
   output logic                 out_valid,
   input  logic                 out_ready,
   output owm_pkg::owm_rsp_type rsp_out
);
   import owm_pkg::*;

   logic        valid_ff;
   owm_rsp_type data_ff;

   // a new response may enter in the same cycle the held one leaves
   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign rsp_out   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

endmodule

FILE: rtl/onewire_master_sequencer.sv
// Top level of the tick-driven 1-Wire master sequencer: csr registers,
// sequencer and result register. Depends on owm_pkg, owm_step, owm_outreg.
//
// channel | dir | handshake               | contents
// req     | in  | req_tvalid/req_tready   | tuser mode, tdata tick/start fields
// rsp     | out | rsp_tvalid/rsp_tready   | tdata line drive, read byte, status
// csr     | in  | csr_valid/csr_ready     | csr_index, csr_data
//
// Each request is one bus tick: it is evaluated combinationally and its response is
// registered for the next cycle; one request per clock unless rsp_tready stalls.
// The result register is the only buffer: req_tready drops only while a held
// response is stalled by rsp_tready. csr_ready is always high.
// Reset (synchronous, active high) idles the sequencer and loads the register
// defaults.
`timescale 1ns / 1ps

module onewire_master_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [0] line_level, [32:1] write_data, [36:33] read_count
   input  logic        req_tuser,  // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // [0] drive_low, [1] byte_valid, [9:2] read_byte,
                                   // [13:10] byte_index, [14] busy_res, [15] done_res,
                                   // [16] no_presence
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import owm_pkg::*;

   owm_cfg_type cfg_ff;
   owm_rsp_type step_rsp;
   owm_rsp_type held_rsp;
   logic        accept;
   logic        can_load;

   assign csr_ready = 1'b1;
   assign req_tready = can_load;
   assign accept = req_tvalid && can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_ticks        <= RST_RESET_TICKS;
         cfg_ff.init_low_ticks     <= RST_INIT_LOW_TICKS;
         cfg_ff.recovery_ticks     <= RST_RECOVERY_TICKS;
         cfg_ff.slot_ticks         <= RST_SLOT_TICKS;
         cfg_ff.sample_delay_ticks <= RST_SAMPLE_DELAY;
         cfg_ff.end_wait_ticks     <= RST_END_WAIT_TICKS;
         cfg_ff.end_wait_periods   <= RST_END_WAIT_PER;
      end else if (csr_valid) begin
         case (csr_index)
            REG_RESET_TICKS:    cfg_ff.reset_ticks        <= csr_data;
            REG_INIT_LOW_TICKS: cfg_ff.init_low_ticks     <= csr_data[7:0];
            REG_RECOVERY_TICKS: cfg_ff.recovery_ticks     <= csr_data[7:0];
            REG_SLOT_TICKS:     cfg_ff.slot_ticks         <= csr_data;
            REG_SAMPLE_DELAY:   cfg_ff.sample_delay_ticks <= csr_data[7:0];
            REG_END_WAIT_TICKS: cfg_ff.end_wait_ticks     <= csr_data;
            REG_END_WAIT_PER:   cfg_ff.end_wait_periods   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   owm_step u_step (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cfg        (cfg_ff),
      .mode       (req_tuser),
      .line_level (req_tdata[0]),
      .write_data (req_tdata[32:1]),
      .read_count (req_tdata[36:33]),
      .rsp        (step_rsp)
   );

   owm_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .rsp_in    (step_rsp),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .rsp_out   (held_rsp)
   );

   assign rsp_tdata = {(RSP_DATA_W - $bits(owm_rsp_type))'(0), held_rsp};

endmodule

FILE: rtl/owm_checker.sv
// Port-level checker for the 1-Wire master sequencer, bound to the top level.
// Depends on onewire_master_sequencer_defines.svh.
`timescale 1ns / 1ps
`include "onewire_master_sequencer_defines.svh"

module owm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   logic rsp_stall;

   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // every accepted request yields a response on the next cycle
   `OWM_ASSERT(a_req_gives_rsp, (req_tvalid && req_tready) |=> rsp_tvalid, "request lost")

   `OWM_ASSERT(a_rsp_hold, rsp_stall |=> (rsp_tvalid && $stable(rsp_tdata)),
               "stalled response changed")

   `OWM_ASSERT(a_nopres_done,
               (rsp_tvalid && rsp_tdata[16]) |-> (rsp_tdata[15] && !rsp_tdata[14]),
               "no_presence without end")

   `OWM_ASSERT(a_byte_fields, (rsp_tvalid && !rsp_tdata[1]) |-> (rsp_tdata[13:2] == 12'd0),
               "byte fields set without byte_valid")

endmodule

bind onewire_master_sequencer owm_checker u_owm_checker (.*);

FILE: dv/onewire_master_sequencer_checker.sv
// Response checker for the 1-Wire master sequencer: tracks the timing registers,
// predicts each response from the accepted requests and compares field by field.
// Depends on owm_pkg.
`timescale 1ns / 1ps

module onewire_master_sequencer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending,
   output logic        seq_active
);
   import owm_pkg::*;

   owm_cfg_type   timing;
   owm_phase_type ph;
   logic [15:0]   tick_cnt;
   logic [31:0]   wr_shift;
   logic [3:0]    bytes_left;
   logic [3:0]    bytes_total;
   logic [2:0]    bit_pos;
   logic [7:0]    rd_shift;
   logic [3:0]    period_cnt;
   logic          presence;

   owm_rsp_type   expected_rsp_q[$];
   owm_rsp_type   want;
   owm_rsp_type   got;

   assign seq_active = (ph != PH_IDLE);

   // Advances the bus sequencer by one request and returns the response it causes.
   function automatic owm_rsp_type advance_bus(input logic mode, input logic line,
                                               input logic [31:0] wdata,
                                               input logic [3:0] rcnt);
      owm_rsp_type r;
      int unsigned span;
      int unsigned periods_needed;
      logic        finished;
      r = '0;
      finished = 1'b0;
      case (ph)
         PH_RESET_LOW, PH_INIT_LOW: r.drive_low = 1'b1;
         PH_HOLD: r.drive_low = (wr_shift != 32'd0) && !wr_shift[0];
         default: r.drive_low = 1'b0;
      endcase
      if (mode == MODE_START) begin
         // a start while busy changes nothing
         if (ph == PH_IDLE) begin
            bytes_left  = (rcnt > MAX_READ_BYTES) ? 4'(MAX_READ_BYTES) : rcnt;
            bytes_total = bytes_left;
            wr_shift    = wdata;
            bit_pos     = '0;
            rd_shift    = '0;
            period_cnt  = '0;
            presence    = 1'b0;
            ph          = PH_RESET_LOW;
            tick_cnt    = '0;
         end
      end else if (ph != PH_IDLE) begin
         case (ph)
            PH_RESET_LOW, PH_PRESENCE: span = timing.reset_ticks;
            PH_RECOVERY:   span = timing.recovery_ticks;
            PH_INIT_LOW:   span = timing.init_low_ticks;
            PH_READ_DELAY: span = timing.sample_delay_ticks;
            PH_HOLD:       span = timing.slot_ticks;
            default:       span = timing.end_wait_ticks;
         endcase
         if (span == 0) span = 1;   // a zero register still lasts one tick
         if (ph == PH_PRESENCE && !line) presence = 1'b1;
         tick_cnt = tick_cnt + 16'd1;
         if (tick_cnt >= span) begin
            tick_cnt = '0;
            case (ph)
               PH_RESET_LOW: ph = PH_PRESENCE;
               PH_PRESENCE: begin
                  if (presence) begin
                     ph = PH_RECOVERY;
                  end else begin
                     ph = PH_IDLE;
                     finished = 1'b1;
                     r.no_presence = 1'b1;
                  end
               end
               PH_RECOVERY: begin
                  if (wr_shift != 32'd0 || bytes_left != 4'd0) begin
                     ph = PH_INIT_LOW;
                  end else begin
                     period_cnt = '0;
                     ph = PH_END_WAIT;
                  end
               end
               PH_INIT_LOW: ph = (wr_shift != 32'd0) ? PH_HOLD : PH_READ_DELAY;
               PH_READ_DELAY: begin
                  rd_shift[bit_pos] = rd_shift[bit_pos] | line;
                  bit_pos = bit_pos + 3'd1;
                  if (bit_pos == 3'd0) begin
                     r.byte_valid = 1'b1;
                     r.read_byte  = rd_shift;
                     r.byte_index = bytes_total - bytes_left;
                     rd_shift     = '0;
                     if (bytes_left != 4'd0) bytes_left = bytes_left - 4'd1;
                  end
                  ph = PH_HOLD;
               end
               PH_HOLD: begin
                  wr_shift = wr_shift >> 1;
                  ph = PH_RECOVERY;
               end
               default: begin
                  period_cnt = period_cnt + 4'd1;
                  periods_needed = (timing.end_wait_periods == 4'd0) ? 1 :
                                   timing.end_wait_periods;
                  if (period_cnt >= periods_needed) begin
                     period_cnt = '0;
                     ph = PH_IDLE;
                     finished = 1'b1;
                  end
               end
            endcase
         end
      end
      r.done_res = finished;
      r.busy_res = (ph != PH_IDLE);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [7:0] exp_val,
                              input logic [7:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         timing = '{RST_RESET_TICKS, RST_INIT_LOW_TICKS, RST_RECOVERY_TICKS,
                    RST_SLOT_TICKS, RST_SAMPLE_DELAY, RST_END_WAIT_TICKS,
                    RST_END_WAIT_PER};
         ph          = PH_IDLE;
         tick_cnt    = '0;
         wr_shift    = '0;
         bytes_left  = '0;
         bytes_total = '0;
         bit_pos     = '0;
         rd_shift    = '0;
         period_cnt  = '0;
         presence    = 1'b0;
         expected_rsp_q.delete();
         fail_count  = 0;
         pending     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_RESET_TICKS:    timing.reset_ticks        = csr_data;
               REG_INIT_LOW_TICKS: timing.init_low_ticks     = csr_data[7:0];
               REG_RECOVERY_TICKS: timing.recovery_ticks     = csr_data[7:0];
               REG_SLOT_TICKS:     timing.slot_ticks         = csr_data;
               REG_SAMPLE_DELAY:   timing.sample_delay_ticks = csr_data[7:0];
               REG_END_WAIT_TICKS: timing.end_wait_ticks     = csr_data;
               REG_END_WAIT_PER:   timing.end_wait_periods   = csr_data[3:0];
               default: ;
            endcase
         end
         // responses are registered, so one leaving now belongs to an older request
         if (rsp_tvalid && rsp_tready) begin
            got = owm_rsp_type'(rsp_tdata[16:0]);
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding: %h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               check_field("drive_low",   want.drive_low,   got.drive_low);
               check_field("byte_valid",  want.byte_valid,  got.byte_valid);
               check_field("read_byte",   want.read_byte,   got.read_byte);
               check_field("byte_index",  want.byte_index,  got.byte_index);
               check_field("busy_res",    want.busy_res,    got.busy_res);
               check_field("done_res",    want.done_res,    got.done_res);
               check_field("no_presence", want.no_presence, got.no_presence);
            end
         end
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(advance_bus(req_tuser, req_tdata[0], req_tdata[32:1],
                                                 req_tdata[36:33]));
         pending = expected_rsp_q.size();
      end
   end

endmodule

FILE: dv/onewire_master_sequencer_tb.sv
// Testbench top for the 1-Wire master sequencer: clock, reset, request and
// register stimulus, response back-pressure and the final verdict.
// Depends on owm_pkg, onewire_master_sequencer and onewire_master_sequencer_checker.
`timescale 1ns / 1ps

module onewire_master_sequencer_tb;
   import owm_pkg::*;

   localparam int             TOTAL_ITEMS  = 950;
   localparam int             HOLD_CYCLES  = 300;
   localparam int             CYCLE_LIMIT  = 2_000_000;
   localparam logic [2:0]     REG_NONE     = 3'd7;   // decodes to no register

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // [0] line_level, [32:1] write_data, [36:33] read_count
   logic        req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [0] drive_low, [1] byte_valid, [9:2] read_byte,
                             // [13:10] byte_index, [14] busy_res, [15] done_res,
                             // [16] no_presence
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   int          fail_count;
   int          pending;
   logic        seq_active;
   int          item_count;
   int          cycle_count;
   bit          pace_on   = 1'b1;
   bit          long_hold = 1'b0;

   always #5 clock = ~clock;

   onewire_master_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   onewire_master_sequencer_checker bus_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending),
      .seq_active (seq_active)
   );

   // Called at a falling edge; returns at the falling edge after the request is taken.
   // req_tvalid stays high so that a back-to-back request keeps the bus busy.
   task automatic push_request(input logic mode, input logic line,
                               input logic [31:0] wdata, input logic [3:0] rcnt);
      int gap;
      gap = pace_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {3'b000, rcnt, wdata, line};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Optional ignored lead tick, one start, then bus ticks (with random restarts) until idle.
   task automatic run_transaction(input logic [31:0] wdata, input logic [3:0] rcnt,
                                  input int low_pct, input int restart_pct,
                                  input bit lead_tick);
      logic line_lvl;
      if (lead_tick) begin
         push_request(MODE_TICK, 1'($urandom), $urandom, 4'($urandom));   // ignored
         item_count++;
      end
      push_request(MODE_START, 1'($urandom), wdata, rcnt);
      item_count++;
      while (seq_active) begin
         line_lvl = ($urandom_range(1, 100) <= low_pct) ? 1'b0 : 1'b1;
         if ($urandom_range(1, 100) <= restart_pct)
            push_request(MODE_START, line_lvl, $urandom, 4'($urandom));
         else
            push_request(MODE_TICK, line_lvl, $urandom, 4'($urandom));
         item_count++;
      end
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // Registers change only with the sequencer idle and no response outstanding.
   task automatic program_timing(input owm_cfg_type c);
      while (pending != 0 || seq_active) @(negedge clock);
      repeat (3) @(negedge clock);
      write_reg(REG_RESET_TICKS,    c.reset_ticks);
      write_reg(REG_INIT_LOW_TICKS, {8'h00, c.init_low_ticks});
      write_reg(REG_RECOVERY_TICKS, {8'h00, c.recovery_ticks});
      write_reg(REG_SLOT_TICKS,     c.slot_ticks);
      write_reg(REG_SAMPLE_DELAY,   {8'h00, c.sample_delay_ticks});
      write_reg(REG_END_WAIT_TICKS, c.end_wait_ticks);
      write_reg(REG_END_WAIT_PER,   {12'h000, c.end_wait_periods});
      write_reg(REG_NONE,           16'($urandom));
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Short timings keep transactions to a few dozen ticks; zeros included.
   function automatic owm_cfg_type short_timing();
      owm_cfg_type c;
      c.reset_ticks        = 16'($urandom_range(0, 4));
      c.init_low_ticks     = 8'($urandom_range(0, 3));
      c.recovery_ticks     = 8'($urandom_range(0, 3));
      c.slot_ticks         = 16'($urandom_range(0, 4));
      c.sample_delay_ticks = 8'($urandom_range(0, 3));
      c.end_wait_ticks     = 16'($urandom_range(0, 6));
      c.end_wait_periods   = 4'($urandom_range(0, 3));
      return c;
   endfunction

   // Sink side: random stalls, plus one long hold-off on request from the stimulus.
   initial begin : sink
      int stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = pace_on ? $urandom_range(0, 11) : 0;
         if (long_hold) begin
            stall = HOLD_CYCLES;
            long_hold = 1'b0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      logic [31:0] wdata;
      logic [3:0]  rcnt;
      int          txn;
      int          low_pct;
      req_tvalid = 1'b0;
      req_tuser  = MODE_TICK;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      item_count = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sink backs off for a long stretch while requests keep coming
      program_timing(owm_cfg_type'{16'd3, 8'd1, 8'd1, 16'd2, 8'd1, 16'd2, 4'd1});
      long_hold = 1'b1;
      run_transaction(32'h8000_0000, 4'd1, 50, 0, 1'b0);
      // no device ever answers: the presence window runs out
      run_transaction(32'h0000_0001, 4'd2, 0, 0, 1'b0);

      // all registers zero: every phase lasts a single tick
      program_timing('0);
      run_transaction(32'h0000_0003, 4'd1, 50, 0, 1'b0);
      run_transaction(32'h0000_0000, 4'd0, 50, 0, 1'b0);

      // byte-wide registers and the period count at their top values
      program_timing(owm_cfg_type'{16'd2, 8'd255, 8'd255, 16'd1, 8'd255, 16'd1, 4'd15});
      run_transaction(32'h0000_0000, 4'd0, 50, 0, 1'b0);

      txn = 0;
      while (item_count < TOTAL_ITEMS) begin
         if (txn % 6 == 0) program_timing(short_timing());
         pace_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 5))
            0: wdata = $urandom;
            1: wdata = 32'($urandom_range(0, 1)) << $urandom_range(0, 31);
            default: wdata = $urandom >> $urandom_range(22, 31);
         endcase
         rcnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
                                              4'($urandom_range(0, 1));
         low_pct = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(20, 80);
         run_transaction(wdata, rcnt, low_pct, ($urandom_range(0, 3) == 0) ? 3 : 0,
                         ($urandom_range(0, 9) == 0));
         txn++;
      end

      pace_on = 1'b1;
      while (pending != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/owm_pkg.sv
rtl/owm_step.sv
rtl/owm_outreg.sv
rtl/onewire_master_sequencer.sv
rtl/owm_checker.sv
dv/onewire_master_sequencer_checker.sv
dv/onewire_master_sequencer_tb.sv
